>>> rtl/mbtc_pkg.sv
package mbtc_pkg;

   localparam int PosWidth = 17;
   localparam logic [PosWidth-1:0] PosMax = '1;

   localparam logic [1:0] VerdictOk      = 2'd0;
   localparam logic [1:0] VerdictBadProto = 2'd1;
   localparam logic [1:0] VerdictShort   = 2'd2;
   localparam logic [1:0] VerdictIgnored = 2'd3;

   localparam logic [1:0] ClassNone   = 2'd0;
   localparam logic [1:0] ClassPublic = 2'd1;
   localparam logic [1:0] ClassUser   = 2'd2;

   localparam logic [2:0] SubNone     = 3'd0;
   localparam logic [2:0] SubReserved = 3'd1;
   localparam logic [2:0] SubKnown    = 3'd2;
   localparam logic [2:0] SubUnused   = 3'd3;
   localparam logic [2:0] SubEncap    = 3'd4;

   localparam logic [6:0] FuncDiag = 7'h08;
   localparam logic [6:0] FuncMei  = 7'h2b;

   localparam logic       CsrIgnoreLow  = 1'b0;
   localparam logic       CsrIgnoreHigh = 1'b1;

   localparam int QueueDepth = 4;

   // Header snapshot of one finished frame, handed from front to back
   typedef struct packed {
      logic        short_frame;
      logic        bad_proto;
      logic [15:0] trans_id;
      logic [7:0]  unit_id;
      logic [7:0]  func_byte;
      logic [15:0] payload;
      logic        is_response;
      logic        ignored;
   } frame_type;

   localparam int FrameWidth = $bits(frame_type);

   typedef struct packed {
      logic [1:0]  verdict;
      logic [15:0] transaction_id;
      logic [7:0]  unit_id;
      logic [6:0]  function_code;
      logic        exception_flag;
      logic        unknown_function;
      logic [1:0]  function_class;
      logic [2:0]  function_subtype;
      logic [15:0] diag_subcode;
      logic [7:0]  mei_type;
      logic [7:0]  exception_code;
   } result_type;

   function automatic logic is_standard(input logic [6:0] f);
      return (f >= 7'h01 && f <= 7'h08) || f == 7'h0b || f == 7'h0c ||
             (f >= 7'h0f && f <= 7'h11) || (f >= 7'h14 && f <= 7'h18) || f == FuncMei;
   endfunction

   function automatic logic [1:0] class_of(input logic [6:0] f);
      if (f == 7'h00) return ClassNone;
      if ((f >= 7'h41 && f <= 7'h48) || (f >= 7'h64 && f <= 7'h6e)) return ClassUser;
      return ClassPublic;
   endfunction

   function automatic logic [2:0] subtype_of(input logic [6:0] f, input logic [15:0] sub);
      priority if (f == 7'h00) return SubNone;
      else if (f <= 7'h07) return SubKnown;
      else if (f == FuncDiag)
         return (sub <= 16'h0012 || sub == 16'h0014) ? SubKnown : SubReserved;
      else if (f <= 7'h0a) return SubReserved;
      else if (f <= 7'h0c) return SubKnown;
      else if (f <= 7'h0e) return SubReserved;
      else if (f <= 7'h11) return SubKnown;
      else if (f <= 7'h13) return SubUnused;
      else if (f <= 7'h28) return SubKnown;
      else if (f <= 7'h2a) return SubReserved;
      else if (f == FuncMei)
         return (sub == 16'h000d || sub == 16'h000e) ? SubEncap : SubReserved;
      else if (f <= 7'h40) return SubUnused;
      else if (f <= 7'h48) return SubNone;
      else if (f <= 7'h59) return SubUnused;
      else if (f <= 7'h5b) return SubReserved;
      else if (f <= 7'h63) return SubUnused;
      else if (f <= 7'h6e) return SubNone;
      else if (f <= 7'h7c) return SubUnused;
      else return SubReserved;
   endfunction

endpackage

>>> rtl/mbtc_front.sv
module mbtc_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic                csr_index,
   input  logic [63:0]         csr_data,
   input  logic                in_valid,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   input  logic                in_resp,
   output logic                in_ready,
   output logic                frm_valid,
   output mbtc_pkg::frame_type frm_data,
   input  logic                frm_ready
);
   import mbtc_pkg::*;

   logic [PosWidth-1:0] pos_ff, pos_in;
   logic [15:0] tid_ff, pid_ff, len_ff, pay_ff;
   logic [7:0]  unit_ff, func_ff;
   logic [63:0] mlo_ff, mhi_ff;
   logic        take;
   logic [15:0] tid_n, pid_n, len_n, pay_n;
   logic [7:0]  unit_n, func_n;
   logic [PosWidth:0] count;

   assign in_ready = frm_ready;
   assign take = in_valid && in_ready;

   always_comb begin
      tid_n = tid_ff; pid_n = pid_ff; len_n = len_ff; pay_n = pay_ff;
      unit_n = unit_ff; func_n = func_ff;
      unique case (pos_ff)
         17'd0: tid_n[15:8] = in_byte;
         17'd1: tid_n[7:0]  = in_byte;
         17'd2: pid_n[15:8] = in_byte;
         17'd3: pid_n[7:0]  = in_byte;
         17'd4: len_n[15:8] = in_byte;
         17'd5: len_n[7:0]  = in_byte;
         17'd6: unit_n      = in_byte;
         17'd7: func_n      = in_byte;
         17'd8: pay_n[15:8] = in_byte;
         17'd9: pay_n[7:0]  = in_byte;
         default: ;
      endcase
      pos_in = (pos_ff == PosMax) ? pos_ff : pos_ff + 1'b1;
      count = {1'b0, pos_ff} + 1'b1;
   end

   always_comb begin
      frm_valid = take && in_last;
      frm_data.trans_id = tid_n;
      frm_data.unit_id = unit_n;
      frm_data.func_byte = func_n;
      frm_data.payload = pay_n;
      frm_data.is_response = in_resp;
      frm_data.bad_proto = (count >= 18'd4) && (pid_n != 16'd0);
      frm_data.short_frame = (count < 18'd4) ||
         (pid_n == 16'd0 && (count < 18'd8 || (count - 18'd6) < {2'b00, len_n}));
      frm_data.ignored = func_n[6] ? mhi_ff[func_n[5:0]] : mlo_ff[func_n[5:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; tid_ff <= '0; pid_ff <= '0; len_ff <= '0;
         pay_ff <= '0; unit_ff <= '0; func_ff <= '0;
         mlo_ff <= '0; mhi_ff <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CsrIgnoreLow:  mlo_ff <= csr_data;
               CsrIgnoreHigh: mhi_ff <= csr_data;
            endcase
         end
         if (take) begin
            if (in_last) begin
               pos_ff <= '0; tid_ff <= '0; pid_ff <= '0; len_ff <= '0;
               pay_ff <= '0; unit_ff <= '0; func_ff <= '0;
            end else begin
               pos_ff <= pos_in; tid_ff <= tid_n; pid_ff <= pid_n; len_ff <= len_n;
               pay_ff <= pay_n; unit_ff <= unit_n; func_ff <= func_n;
            end
         end
      end
   end
endmodule

>>> rtl/mbtc_queue.sv
module mbtc_queue #(
   parameter int Width = mbtc_pkg::FrameWidth,
   parameter int Depth = mbtc_pkg::QueueDepth
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  logic [Width-1:0] push_data,
   output logic             push_ready,
   output logic             pop_valid,
   output logic [Width-1:0] pop_data,
   input  logic             pop_ready
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

   logic [Width-1:0] mem_ff [Depth];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;
   logic push, pop;

   assign push_ready = cnt_ff != Depth[AW:0];
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = mem_ff[rp_ff];
   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(Depth - 1)) ? '0 : wp_ff + 1'b1;
         if (pop)  rp_ff <= (rp_ff == AW'(Depth - 1)) ? '0 : rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end
endmodule

>>> rtl/mbtc_back.sv
module mbtc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 frm_valid,
   input  mbtc_pkg::frame_type  frm_data,
   output logic                 frm_ready,
   output logic                 out_valid,
   output mbtc_pkg::result_type out_data,
   input  logic                 out_ready
);
   import mbtc_pkg::*;

   logic       valid_ff;
   result_type res_ff, res_in;
   logic [6:0] f;
   logic       exc;
   logic [15:0] sub;

   assign frm_ready = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data = res_ff;

   always_comb begin
      f = frm_data.func_byte[6:0];
      exc = frm_data.func_byte[7];
      res_in = '0;
      res_in.transaction_id = frm_data.trans_id;
      sub = '0;
      if (frm_data.bad_proto) begin
         res_in.verdict = VerdictBadProto;
      end else if (frm_data.short_frame) begin
         res_in.verdict = VerdictShort;
      end else begin
         res_in.unit_id = frm_data.unit_id;
         res_in.function_code = f;
         res_in.exception_flag = exc;
         if (frm_data.ignored) begin
            res_in.verdict = VerdictIgnored;
         end else begin
            res_in.verdict = VerdictOk;
            res_in.unknown_function = !is_standard(f);
            res_in.function_class = class_of(f);
            if (frm_data.is_response && exc) begin
               res_in.exception_code = frm_data.payload[15:8];
            end else begin
               if (f == FuncDiag) begin
                  res_in.diag_subcode = frm_data.payload;
                  sub = frm_data.payload;
               end else if (f == FuncMei) begin
                  res_in.mei_type = frm_data.payload[15:8];
                  sub = {8'h00, frm_data.payload[15:8]};
               end
               res_in.function_subtype = subtype_of(f, sub);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (frm_ready) begin
         valid_ff <= frm_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (frm_ready && frm_valid) res_ff <= res_in;
   end
endmodule

>>> rtl/modbus_tcp_header_classifier_top.sv
// Channel | Ports                     | Contents
// req     | req_tvalid/tready/tdata   | frame byte; last_byte on tlast, is_response on tuser
// rsp     | rsp_tvalid/tready/tdata   | verdict and decoded header, one transaction per frame
// csr     | csr_write/index/data      | ignore masks, low (index 0) and high (index 1)
//
// One byte transaction per cycle while req_tready is high. The front captures the header
// bytes, a queue holds up to QueueDepth frames and the back registers the verdict, which is
// held until it is taken.
// Reset is synchronous and clears the byte counter, header capture, masks and queue.
// req_tready drops only when the frame queue is full; rsp stalls fill the queue first.
module modbus_tcp_header_classifier_top #(
   parameter int QueueDepth = mbtc_pkg::QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] frame_byte
   input  logic        req_tlast,   // last_byte
   input  logic        req_tuser,   // [0] is_response
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] verdict, [17:2] transaction_id, [25:18] unit_id, [32:26] function_code,
   // [33] exception_flag, [34] unknown_function, [36:35] function_class,
   // [39:37] function_subtype, [55:40] diag_subcode, [63:56] mei_type,
   // [71:64] exception_code
   output logic [71:0] rsp_tdata,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [63:0] csr_data
);
   import mbtc_pkg::*;

   logic      f_valid, f_ready, q_valid, q_ready;
   frame_type f_data, q_data;
   result_type r;

   mbtc_front u_front (
      .clock, .reset, .csr_write, .csr_index, .csr_data,
      .in_valid(req_tvalid), .in_byte(req_tdata), .in_last(req_tlast),
      .in_resp(req_tuser), .in_ready(req_tready),
      .frm_valid(f_valid), .frm_data(f_data), .frm_ready(f_ready)
   );

   mbtc_queue #(.Width(FrameWidth), .Depth(QueueDepth)) u_queue (
      .clock, .reset,
      .push_valid(f_valid), .push_data(f_data), .push_ready(f_ready),
      .pop_valid(q_valid), .pop_data(q_data), .pop_ready(q_ready)
   );

   mbtc_back u_back (
      .clock, .reset, .frm_valid(q_valid), .frm_data(q_data), .frm_ready(q_ready),
      .out_valid(rsp_tvalid), .out_data(r), .out_ready(rsp_tready)
   );

   assign rsp_tdata = {r.exception_code, r.mei_type, r.diag_subcode, r.function_subtype,
                       r.function_class, r.unknown_function, r.exception_flag,
                       r.function_code, r.unit_id, r.transaction_id, r.verdict};
endmodule

>>> rtl/mbtc_checker.sv
module mbtc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);
   import mbtc_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp dropped or changed under stall");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[1:0] == VerdictBadProto || rsp_tdata[1:0] == VerdictShort)
      |-> rsp_tdata[71:18] == '0)
      else $error("bad or short verdict carries fields");

   a_ign_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == VerdictIgnored |-> rsp_tdata[71:34] == '0)
      else $error("ignored verdict carries class fields");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");
endmodule

bind modbus_tcp_header_classifier_top mbtc_checker u_checker (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata
);

>>> tb/tb_modbus_tcp_header_classifier_top.sv
`timescale 1ns / 100ps

module tb_modbus_tcp_header_classifier_top;
   import mbtc_pkg::*;

   // Scoreboard: holds a copy of the header capture state and the ignore masks.
   // It turns each accepted byte transaction into at most one expected verdict.
   class mbap_scoreboard;
      logic [63:0] mask_low, mask_high;
      int unsigned pos;
      logic [15:0] tid, proto, hdr_len, payload;
      logic [7:0]  unit, func_byte;
      result_type  pending_verdicts[$];
      int          errors;

      function new();
         mask_low = '0;
         mask_high = '0;
         errors = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         pos = 0;
         tid = '0;
         proto = '0;
         hdr_len = '0;
         payload = '0;
         unit = '0;
         func_byte = '0;
      endfunction

      function void set_mask(logic idx, logic [63:0] value);
         if (idx == CsrIgnoreLow) mask_low = value;
         else mask_high = value;
      endfunction

      function logic standard_code(logic [6:0] f);
         case (f)
            7'h01, 7'h02, 7'h03, 7'h04, 7'h05, 7'h06, 7'h07, 7'h08,
            7'h0b, 7'h0c, 7'h0f, 7'h10, 7'h11,
            7'h14, 7'h15, 7'h16, 7'h17, 7'h18, FuncMei: return 1'b1;
            default: return 1'b0;
         endcase
      endfunction

      function logic [2:0] subtype(logic [6:0] f, logic [15:0] sub);
         if (f == 7'h00) return SubNone;
         if (f < 7'h08) return SubKnown;
         if (f == FuncDiag) return (sub < 16'h0013 || sub == 16'h0014) ? SubKnown : SubReserved;
         if (f < 7'h0b) return SubReserved;
         if (f < 7'h0d) return SubKnown;
         if (f < 7'h0f) return SubReserved;
         if (f < 7'h12) return SubKnown;
         if (f < 7'h14) return SubUnused;
         if (f < 7'h29) return SubKnown;
         if (f < 7'h2b) return SubReserved;
         if (f == FuncMei) return (sub == 16'h000d || sub == 16'h000e) ? SubEncap : SubReserved;
         if (f < 7'h41) return SubUnused;
         if (f < 7'h49) return SubNone;
         if (f < 7'h5a) return SubUnused;
         if (f < 7'h5c) return SubReserved;
         if (f < 7'h64) return SubUnused;
         if (f < 7'h6f) return SubNone;
         if (f < 7'h7d) return SubUnused;
         return SubReserved;
      endfunction

      // One accepted request transaction
      function void note_byte(logic [7:0] b, logic last, logic resp);
         result_type  r;
         int unsigned cnt;
         logic [6:0]  f;
         logic        ign;
         cnt = pos + 1;
         case (pos)
            0: tid[15:8] = b;
            1: tid[7:0] = b;
            2: proto[15:8] = b;
            3: proto[7:0] = b;
            4: hdr_len[15:8] = b;
            5: hdr_len[7:0] = b;
            6: unit = b;
            7: func_byte = b;
            8: payload[15:8] = b;
            9: payload[7:0] = b;
            default: ;
         endcase
         if (pos < PosMax) pos++;
         if (!last) return;
         r = '0;
         r.transaction_id = tid;
         if (cnt < 4) r.verdict = VerdictShort;
         else if (proto != 0) r.verdict = VerdictBadProto;
         else if (cnt < 8 || cnt - 6 < hdr_len) r.verdict = VerdictShort;
         else begin
            f = func_byte[6:0];
            r.function_code = f;
            r.exception_flag = func_byte[7];
            r.unit_id = unit;
            ign = f[6] ? mask_high[f[5:0]] : mask_low[f[5:0]];
            if (ign) r.verdict = VerdictIgnored;
            else begin
               r.verdict = VerdictOk;
               r.unknown_function = !standard_code(f);
               if (f == 0) r.function_class = ClassNone;
               else if ((f >= 7'h41 && f <= 7'h48) || (f >= 7'h64 && f <= 7'h6e))
                  r.function_class = ClassUser;
               else r.function_class = ClassPublic;
               if (resp && func_byte[7]) r.exception_code = payload[15:8];
               else if (f == FuncDiag) begin
                  r.diag_subcode = payload;
                  r.function_subtype = subtype(f, payload);
               end else if (f == FuncMei) begin
                  r.mei_type = payload[15:8];
                  r.function_subtype = subtype(f, {8'h00, payload[15:8]});
               end else r.function_subtype = subtype(f, 16'h0000);
            end
         end
         pending_verdicts.push_back(r);
         clear_frame();
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task cmp(string name, int unsigned got, int unsigned want);
         if (got != want) report($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
      endtask

      // One accepted result transaction
      task check_result(logic [71:0] d);
         result_type e;
         if (pending_verdicts.size() == 0) begin
            report($sformatf("unexpected result 0x%0h", d));
            return;
         end
         e = pending_verdicts.pop_front();
         cmp("verdict", d[1:0], e.verdict);
         cmp("transaction_id", d[17:2], e.transaction_id);
         cmp("unit_id", d[25:18], e.unit_id);
         cmp("function_code", d[32:26], e.function_code);
         cmp("exception_flag", d[33], e.exception_flag);
         cmp("unknown_function", d[34], e.unknown_function);
         cmp("function_class", d[36:35], e.function_class);
         cmp("function_subtype", d[39:37], e.function_subtype);
         cmp("diag_subcode", d[55:40], e.diag_subcode);
         cmp("mei_type", d[63:56], e.mei_type);
         cmp("exception_code", d[71:64], e.exception_code);
      endtask
   endclass

   localparam int IdleLimit = 20000;   // cycles with no transaction before giving up
   localparam int Settle    = 12;      // beyond queue depth plus output register

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_write = 1'b0;
   logic        csr_index = CsrIgnoreLow;
   logic [63:0] csr_data = '0;

   mbap_scoreboard sb = new();

   int send_idle_pct  = 0;   // sender gap probability, percent
   int rsp_stall_pct  = 0;   // receiver stall probability, percent
   int bytes_sent     = 0;
   int quiet_cycles   = 0;

   always #1 clock = ~clock;

   modbus_tcp_header_classifier_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // Receiver backpressure, redrawn every cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Monitors: values seen here are the ones present before the edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_byte(req_tdata, req_tlast, req_tuser);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   // Watchdog: any transaction on either side resets the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Drive one byte; valid stays high across back-to-back transactions
   task send_byte(logic [7:0] b, logic last, logic resp);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      req_tuser  <= resp;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
   endtask

   // Lower valid and let every expected verdict come out
   task drain();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      do @(posedge clock); while (sb.pending_verdicts.size() != 0);
      repeat (Settle) @(posedge clock);
   endtask

   // Write enable is left high; the caller lowers it after the last write
   task csr_write_reg(logic idx, logic [63:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      sb.set_mask(idx, value);
   endtask

   // Build and send one frame. len_field < 0 means "exactly fits".
   // Non-last bytes carry a random direction flag: only the last one counts.
   task send_frame(int unsigned n, logic [15:0] tid, logic [15:0] proto, int len_field,
                   logic [7:0] unit, logic [7:0] fb, logic [15:0] pay, logic resp);
      logic [7:0]  b;
      logic [15:0] lf;
      lf = (len_field < 0) ? ((n > 6) ? 16'(n - 6) : 16'h0000) : 16'(len_field);
      for (int unsigned i = 0; i < n; i++) begin
         case (i)
            0: b = tid[15:8];
            1: b = tid[7:0];
            2: b = proto[15:8];
            3: b = proto[7:0];
            4: b = lf[15:8];
            5: b = lf[7:0];
            6: b = unit;
            7: b = fb;
            8: b = pay[15:8];
            9: b = pay[7:0];
            default: b = 8'($urandom_range(255));
         endcase
         send_byte(b, i == n - 1, (i == n - 1) ? resp : 1'($urandom_range(1)));
      end
   endtask

   // Random frame: mostly well formed, with content aimed at the range table edges
   task random_frame();
      int unsigned n;
      int          lf;
      int          pick;
      logic [7:0]  fb;
      logic [15:0] pay;
      logic [15:0] proto;
      pick = $urandom_range(99);
      if (pick < 70) n = $urandom_range(12, 8);
      else if (pick < 85) n = $urandom_range(7, 1);
      else n = $urandom_range(40, 13);
      proto = ($urandom_range(9) == 0) ? 16'($urandom) : 16'h0000;
      pick = $urandom_range(9);
      if (pick < 6) lf = -1;
      else if (pick < 9) lf = $urandom_range(n > 6 ? n - 6 : 0);
      else lf = $urandom_range(65535);
      pick = $urandom_range(9);
      if (pick < 3) fb = {1'($urandom_range(1)), FuncDiag};
      else if (pick < 5) fb = {1'($urandom_range(1)), FuncMei};
      else fb = 8'($urandom_range(255));
      pick = $urandom_range(3);
      if (pick == 0) pay = 16'($urandom_range(21));
      else if (pick == 1) pay = {8'($urandom_range(15, 12)), 8'($urandom)};
      else pay = 16'($urandom);
      send_frame(n, 16'($urandom), proto, lf, 8'($urandom), fb, pay, 1'($urandom_range(1)));
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed frames, masks cleared
      send_frame(1, 16'hffff, '0, -1, '0, '0, '0, 1'b0);               // very short
      send_frame(3, 16'h1234, '0, -1, '0, '0, '0, 1'b1);
      send_frame(4, 16'h0000, '0, -1, '0, '0, '0, 1'b0);               // short, proto ok
      send_frame(7, 16'habcd, '0, -1, 8'hff, 8'h03, '0, 1'b0);
      send_frame(8, 16'h5555, 16'hffff, -1, 8'h01, 8'h01, '0, 1'b0);   // bad protocol id
      send_frame(8, 16'h0001, 16'h0001, 16'hffff, 8'h01, 8'h01, '0, 1'b0); // bad proto first
      send_frame(9, 16'h0002, '0, 4, 8'h01, 8'h01, '0, 1'b0);          // length too large
      send_frame(8, 16'h0003, '0, 0, '0, 8'h00, '0, 1'b0);             // function zero
      send_frame(10, 16'h0004, '0, -1, 8'h11, {1'b0, FuncDiag}, 16'h0012, 1'b0);
      send_frame(10, 16'h0005, '0, -1, 8'h11, {1'b0, FuncDiag}, 16'h0013, 1'b1);
      send_frame(10, 16'h0006, '0, -1, 8'h11, {1'b0, FuncDiag}, 16'h0014, 1'b0);
      send_frame(10, 16'h0007, '0, -1, 8'h11, {1'b0, FuncDiag}, 16'hffff, 1'b0);
      send_frame(9, 16'h0008, '0, -1, 8'h22, {1'b0, FuncMei}, 16'h0d00, 1'b0);
      send_frame(9, 16'h0009, '0, -1, 8'h22, {1'b0, FuncMei}, 16'h0e00, 1'b1);
      send_frame(9, 16'h000a, '0, -1, 8'h22, {1'b0, FuncMei}, 16'h0f00, 1'b0);
      send_frame(9, 16'h000b, '0, -1, 8'h33, 8'h83, 16'h0200, 1'b1);   // exception response
      send_frame(9, 16'h000c, '0, -1, 8'h33, 8'h88, 16'h0400, 1'b0);   // exception bit, request
      send_frame(8, 16'h000d, '0, -1, 8'h44, 8'hff, '0, 1'b0);         // 0x7f
      send_frame(8, 16'h000e, '0, -1, 8'h44, 8'h41, '0, 1'b0);         // user range
      send_frame(8, 16'h000f, '0, -1, 8'h44, 8'h6e, '0, 1'b0);
      drain();   // sender holds off until every verdict is out

      // Random phases, each with its own mask setting and idle pattern
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               csr_write_reg(CsrIgnoreLow, '1);
               csr_write_reg(CsrIgnoreHigh, '0);
               send_idle_pct = 0;  rsp_stall_pct = 0;
            end
            1: begin
               csr_write_reg(CsrIgnoreLow, '0);
               csr_write_reg(CsrIgnoreHigh, '1);
               send_idle_pct = 85; rsp_stall_pct = 0;
            end
            2: begin
               csr_write_reg(CsrIgnoreLow, {$urandom, $urandom});
               csr_write_reg(CsrIgnoreHigh, {$urandom, $urandom});
               send_idle_pct = 0;  rsp_stall_pct = 85;
            end
            default: begin
               csr_write_reg(CsrIgnoreLow, {$urandom, $urandom} & {$urandom, $urandom});
               csr_write_reg(CsrIgnoreHigh, {$urandom, $urandom} & {$urandom, $urandom});
               send_idle_pct = 8;  rsp_stall_pct = 8;
            end
         endcase
         csr_write <= 1'b0;
         bytes_sent = 0;
         while (bytes_sent < 220) random_frame();
         drain();
      end

      if (sb.pending_verdicts.size() != 0)
         sb.report($sformatf("%0d verdicts never arrived", sb.pending_verdicts.size()));
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
